// ===== hdl/sorted_record_table_defines.svh =====
// Assertion macros shared by the sorted record table RTL.
`ifndef SORTED_RECORD_TABLE_DEFINES_SVH
`define SORTED_RECORD_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk with rst_n as the disable.
`define SRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_record_table: same-cycle check failed");
// Next-cycle implication, checked on clk with rst_n as the disable.
`define SRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_record_table: next-cycle check failed");
`else
`define SRT_ASSERT_NOW(lbl, ante, cons)
`define SRT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/srt_pkg.sv =====
// Types and constants shared by the sorted record table modules.
package srt_pkg;

  // Operation codes of a request.
  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_FIND     = 2'd1;
  localparam logic [1:0] OP_RESOLVE  = 2'd2;

  // Result codes.
  localparam logic [2:0] RC_OK        = 3'd0;
  localparam logic [2:0] RC_BAD_KEY   = 3'd1;
  localparam logic [2:0] RC_FULL      = 3'd2;
  localparam logic [2:0] RC_DUPLICATE = 3'd3;
  localparam logic [2:0] RC_NOT_FOUND = 3'd4;

  // Width of the capacity register and of the count port.
  localparam int unsigned CAP_W = 5;

  // One stored record.
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] first_party;
    logic [63:0] second_party;
    logic [63:0] subject;
    logic        resolved;
    logic [63:0] start_time;
    logic [63:0] resolve_time;
    logic [63:0] origin_tag;
  } rec_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic capture;  // compare the request key against the held key
    logic insert;   // open the sorted slot and shift larger entries up
    logic resolve;  // mark the matching entry resolved
  } ctl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE
  } state_t;

endpackage

// ===== hdl/srt_cell.sv =====
// One slot of the sorted chain: holds a record and its compare flags.
`include "sorted_record_table_defines.svh"

module srt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  srt_pkg::ctl_t ctl,
  input  logic          valid,
  input  logic [63:0]   req_key,
  input  logic [63:0]   event_time,
  input  srt_pkg::rec_t new_rec,
  input  srt_pkg::rec_t prev_rec,
  input  logic          prev_lt,
  output srt_pkg::rec_t rec,
  output logic          lt,
  output logic          eq
);

  srt_pkg::rec_t rec_r, rec_nxt;
  logic          lt_r, lt_nxt;
  logic          eq_r, eq_nxt;

  // Compare on capture; shift, load or resolve on update.
  always_comb begin
    rec_nxt = rec_r;
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    if (ctl.capture) begin
      lt_nxt = valid && (rec_r.key < req_key);
      eq_nxt = valid && (rec_r.key == req_key);
    end
    if (ctl.insert && !lt_r) begin
      // The first slot not below the key takes the new record; the rest take the neighbor.
      rec_nxt = prev_lt ? new_rec : prev_rec;
    end
    if (ctl.resolve && eq_r) begin
      rec_nxt.resolved     = 1'b1;
      rec_nxt.resolve_time = event_time;
    end
  end

  // Record payload needs no reset.
  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  // Compare flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  assign rec = rec_r;
  assign lt  = lt_r;
  assign eq  = eq_r;

  // An entry never matches and lies below the key at once.
  `SRT_ASSERT_NOW(a_cell_flags_exclusive, 1'b1, !(lt_r && eq_r))
  // Flags change only after a capture.
  `SRT_ASSERT_NEXT(a_cell_flags_hold, !ctl.capture, $stable(lt_r) && $stable(eq_r))
  // Insert and resolve are never requested together.
  `SRT_ASSERT_NOW(a_cell_one_update, ctl.insert, !ctl.resolve && !ctl.capture)

endmodule

// ===== hdl/sorted_record_table.sv =====
// Sorted record table: a chain of cells kept in ascending key order.
// A request accepted in idle passes the compare and update states, then out_valid rises.
// One request at a time (capture, compare in the cells, update); start is taken only in idle.
// All cells compare and shift in parallel, so table depth does not slow a request down.
// Reset (synchronous, rst_n low) empties the table and sets the capacity limit to 16.
// Results are strobed for one cycle; the receiver cannot stall.
`include "sorted_record_table_defines.svh"

module sorted_record_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_key,
  input  logic [63:0] in_first_party,
  input  logic [63:0] in_second_party,
  input  logic [63:0] in_subject,
  input  logic [63:0] in_event_time,
  input  logic [63:0] in_origin_tag,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_capacity_limit,
  output logic        out_valid,
  output logic [2:0]  out_result_code,
  output logic        out_hit,
  output logic [63:0] out_first_party,
  output logic [63:0] out_second_party,
  output logic [63:0] out_subject,
  output logic        out_is_resolved,
  output logic [63:0] out_start_time,
  output logic [63:0] out_resolve_time,
  output logic [63:0] out_origin_tag,
  output logic [4:0]  out_entry_count
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > srt_pkg::CAP_W) ? CNT_W : srt_pkg::CAP_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

  srt_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [4:0]       cap_r;

  // Captured request.
  logic [1:0]  op_r;
  logic [63:0] key_r, fp_r, sp_r, subj_r, time_r, origin_r;

  // Result registers.
  logic          valid_r, valid_nxt;
  logic [2:0]    code_r, code_nxt;
  logic          hit_r, hit_nxt;
  srt_pkg::rec_t orec_r, orec_nxt;
  logic [CNT_W-1:0] ocount_r;

  srt_pkg::ctl_t ctl;
  srt_pkg::rec_t new_rec, match_rec;
  srt_pkg::rec_t cell_rec [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_lt, cell_eq, cell_valid;
  logic dup, full;
  logic [CMP_W-1:0] cap_eff, count_ext;

  assign busy = (state_r != srt_pkg::ST_IDLE);

  // Record built from the request, as register would store it.
  always_comb begin
    new_rec              = '0;
    new_rec.key          = key_r;
    new_rec.first_party  = fp_r;
    new_rec.second_party = sp_r;
    new_rec.subject      = subj_r;
    new_rec.resolved     = 1'b0;
    new_rec.start_time   = time_r;
    new_rec.resolve_time = '0;
    new_rec.origin_tag   = (origin_r != '0) ? origin_r : key_r;
  end

  // Cell chain: each cell sees its lower neighbor's record and compare flag.
  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      assign cell_valid[gi] = (CNT_W'(gi) < count_r);
      if (gi == 0) begin : g_first
        srt_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctl        (ctl),
          .valid      (cell_valid[gi]),
          .req_key    (key_r),
          .event_time (time_r),
          .new_rec    (new_rec),
          .prev_rec   (new_rec),
          .prev_lt    (1'b1),
          .rec        (cell_rec[gi]),
          .lt         (cell_lt[gi]),
          .eq         (cell_eq[gi])
        );
      end else begin : g_rest
        srt_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctl        (ctl),
          .valid      (cell_valid[gi]),
          .req_key    (key_r),
          .event_time (time_r),
          .new_rec    (new_rec),
          .prev_rec   (cell_rec[gi-1]),
          .prev_lt    (cell_lt[gi-1]),
          .rec        (cell_rec[gi]),
          .lt         (cell_lt[gi]),
          .eq         (cell_eq[gi])
        );
      end
    end
  endgenerate

  // Keys are unique, so at most one cell matches; OR the matching record out.
  always_comb begin
    match_rec = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cell_eq[i]) begin
        match_rec = match_rec | cell_rec[i];
      end
    end
  end

  // Register checks.
  assign dup       = |cell_eq;
  assign count_ext = CMP_W'(count_r);
  assign cap_eff   = (CMP_W'(cap_r) < DEPTH_C) ? CMP_W'(cap_r) : DEPTH_C;
  assign full      = (count_ext >= cap_eff);

  // Sequencer, cell commands and result formation.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ctl         = '0;
    valid_nxt   = 1'b0;
    code_nxt    = code_r;
    hit_nxt     = hit_r;
    orec_nxt    = orec_r;
    case (state_r)
      srt_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = srt_pkg::ST_COMPARE;
        end
      end
      srt_pkg::ST_COMPARE: begin
        ctl.capture = 1'b1;
        state_nxt   = srt_pkg::ST_UPDATE;
      end
      srt_pkg::ST_UPDATE: begin
        state_nxt = srt_pkg::ST_IDLE;
        valid_nxt = 1'b1;
        code_nxt  = srt_pkg::RC_NOT_FOUND;
        hit_nxt   = 1'b0;
        orec_nxt  = '0;
        case (op_r)
          srt_pkg::OP_REGISTER: begin
            if (key_r == '0) begin
              code_nxt = srt_pkg::RC_BAD_KEY;
            end else if (full) begin
              code_nxt = srt_pkg::RC_FULL;
            end else if (dup) begin
              code_nxt = srt_pkg::RC_DUPLICATE;
            end else begin
              code_nxt   = srt_pkg::RC_OK;
              hit_nxt    = 1'b1;
              orec_nxt   = new_rec;
              ctl.insert = 1'b1;
              count_nxt  = count_r + CNT_W'(1);
            end
          end
          srt_pkg::OP_FIND: begin
            if (dup) begin
              code_nxt = srt_pkg::RC_OK;
              hit_nxt  = 1'b1;
              orec_nxt = match_rec;
            end
          end
          srt_pkg::OP_RESOLVE: begin
            if (dup) begin
              code_nxt              = srt_pkg::RC_OK;
              hit_nxt               = 1'b1;
              orec_nxt              = match_rec;
              orec_nxt.resolved     = 1'b1;
              orec_nxt.resolve_time = time_r;
              ctl.resolve           = 1'b1;
            end
          end
          default: begin
            code_nxt = srt_pkg::RC_NOT_FOUND;
          end
        endcase
      end
      default: begin
        state_nxt = srt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srt_pkg::ST_IDLE;
      count_r <= '0;
      cap_r   <= 5'd16;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_capacity_limit;
      end
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r     <= in_op;
      key_r    <= in_key;
      fp_r     <= in_first_party;
      sp_r     <= in_second_party;
      subj_r   <= in_subject;
      time_r   <= in_event_time;
      origin_r <= in_origin_tag;
    end
    code_r   <= code_nxt;
    hit_r    <= hit_nxt;
    orec_r   <= orec_nxt;
    ocount_r <= count_nxt;
  end

  assign out_valid        = valid_r;
  assign out_result_code  = code_r;
  assign out_hit          = hit_r;
  assign out_first_party  = orec_r.first_party;
  assign out_second_party = orec_r.second_party;
  assign out_subject      = orec_r.subject;
  assign out_is_resolved  = orec_r.resolved;
  assign out_start_time   = orec_r.start_time;
  assign out_resolve_time = orec_r.resolve_time;
  assign out_origin_tag   = orec_r.origin_tag;
  assign out_entry_count  = srt_pkg::CAP_W'(ocount_r);

  // Keys in the table are unique, so the compare phase finds at most one match.
  `SRT_ASSERT_NOW(a_single_match, state_r == srt_pkg::ST_UPDATE, $onehot0(cell_eq))
  // Every update cycle is followed by exactly one result strobe.
  `SRT_ASSERT_NEXT(a_update_strobes, state_r == srt_pkg::ST_UPDATE, valid_r)
  // An accepted request moves the sequencer into the compare phase.
  `SRT_ASSERT_NEXT(a_accept_busy, start && !busy, state_r == srt_pkg::ST_COMPARE)
  // A hit is reported exactly when the operation succeeded.
  `SRT_ASSERT_NOW(a_hit_matches_ok, valid_r, hit_r == (code_r == srt_pkg::RC_OK))
  // The fill count never passes the table depth.
  `SRT_ASSERT_NOW(a_count_bound, 1'b1, CMP_W'(count_r) <= DEPTH_C)

endmodule
